### rtl/core/svx_pkg.sv
// Shared types, constants and a helper function of the stack-machine execution unit.
package svx_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CODE_SIZE   = 1024;
  localparam int unsigned DATA_WORDS  = 256;
  localparam int unsigned GPIO_PINS   = 32;

  localparam int unsigned SP_W   = $clog2(STACK_DEPTH);
  localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DADDR_W = $clog2(DATA_WORDS);
  localparam logic [31:0] ADDR_MASK = 32'h0000_00FF;

  localparam logic [4:0] OP_STOP = 5'd0,  OP_PUSH = 5'd1,  OP_BXOR = 5'd2,  OP_DROP = 5'd3;
  localparam logic [4:0] OP_ADD  = 5'd4,  OP_SUB  = 5'd5,  OP_MUL  = 5'd6,  OP_DIV  = 5'd7;
  localparam logic [4:0] OP_MOD  = 5'd8,  OP_NOT  = 5'd9,  OP_AND  = 5'd10, OP_OR   = 5'd11;
  localparam logic [4:0] OP_BNOT = 5'd12, OP_BAND = 5'd13, OP_BOR  = 5'd14, OP_GPIN = 5'd15;
  localparam logic [4:0] OP_GPOUT = 5'd16, OP_PUT = 5'd17, OP_GET = 5'd18, OP_JT = 5'd19;
  localparam logic [4:0] OP_EQ   = 5'd20, OP_NEQ  = 5'd21, OP_GEQ  = 5'd22, OP_LEQ  = 5'd23;
  localparam logic [4:0] OP_GT   = 5'd24, OP_LT   = 5'd25;

  localparam logic [2:0] ST_OK = 3'd0, ST_UNDER = 3'd1, ST_OVER = 3'd2;
  localparam logic [2:0] ST_CODE = 3'd3, ST_DIVZ = 3'd4, ST_PIN = 3'd5;

  typedef struct packed {
    logic [4:0]         mode;
    logic signed [31:0] immediate;
    logic [10:0]        code_pos;
    logic [31:0]        gpio_levels;
    logic [31:0]        observed_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [10:0]        next_code_pos;
    logic signed [31:0] pushed_value;
    logic               gpio_write;
    logic [4:0]         gpio_pin;
    logic               gpio_value;
    logic [31:0]        max_time;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic div_start;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_mem;
    logic need_div;
    logic div_done;
  } stat_t;

  function automatic logic [1:0] pops_needed(input logic [4:0] op);
    logic [1:0] n;
    unique case (op) inside
      OP_STOP, OP_PUSH: n = 2'd0;
      OP_DROP, OP_NOT, OP_BNOT, OP_GPIN, OP_GET: n = 2'd1;
      OP_BXOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_BAND,
      OP_BOR, OP_GPOUT, OP_PUT, OP_JT, OP_EQ, OP_NEQ, OP_GEQ, OP_LEQ, OP_GT,
      OP_LT: n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/svx_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle.
module svx_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);
  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic        negq_q, negq_d, nega_q, nega_d;
  logic [32:0] shifted;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    negq_d = negq_q;
    nega_d = nega_q;
    done_d = 1'b0;
    shifted = {rem_q, quo_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[31] ? -dividend_i : dividend_i;
      den_d  = divisor_i[31] ? -divisor_i : divisor_i;
      nega_d = dividend_i[31];
      negq_d = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        rem_d    = 32'(shifted - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = shifted[31:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    negq_q <= negq_d;
    nega_q <= nega_d;
  end

  assign done_o = done_q;
  assign quo_o  = negq_q ? -quo_q : quo_q;
  assign rem_o  = nega_q ? -rem_q : rem_q;
endmodule

### rtl/core/svx_ctrl.sv
// Sequencing state machine of the execution unit.
module svx_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  svx_pkg::stat_t stat_i,
  output svx_pkg::cmd_t  cmd_o
);
  import svx_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_EXEC} state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.need_mem) begin
          cmd_o.mem_rd = 1'b1;
          state_d = S_EXEC;
        end else if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = cmd_o.commit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
endmodule

### rtl/core/svx_datapath.sv
// Stack, data memory, execute logic and result register of the execution unit.
module svx_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  svx_pkg::cmd_t        cmd_i,
  output svx_pkg::stat_t       stat_o,
  input  svx_pkg::in_item_t    in_item_i,
  output svx_pkg::out_item_t   out_item_o
);
  import svx_pkg::*;

  in_item_t                item_q;
  logic [31:0]             stack_mem [STACK_DEPTH];
  logic [31:0]             top_q, below_q;
  logic [DEPTH_W-1:0]      depth_q;
  logic [31:0]             dmem [DATA_WORDS];
  logic [DATA_WORDS-1:0]   dvalid_q;
  logic [31:0]             drd_q;
  logic                    drd_valid_q;
  logic [31:0]             max_q;
  out_item_t               out_q;

  logic                    div_done;
  logic [31:0]             quo, rem;

  logic [DEPTH_W-1:0]      d_m1, d_m2, d_pop, d_new;
  logic [1:0]              npop;
  logic [2:0]              st;
  logic [10:0]             nxt;
  logic [31:0]             res, mul_lo;
  logic                    push;
  logic [11:0]             pos_plus4;
  logic [DADDR_W-1:0]      daddr;
  logic signed [31:0]      s1, s2;
  logic                    ok;
  out_item_t               out_d;

  svx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (below_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  assign d_m1  = depth_q - DEPTH_W'(1);
  assign d_m2  = depth_q - DEPTH_W'(2);
  assign npop  = pops_needed(item_q.mode);
  assign d_pop = depth_q - DEPTH_W'(npop);
  assign daddr = DADDR_W'(top_q & ADDR_MASK);
  assign s1    = $signed(below_q);
  assign s2    = $signed(top_q);
  assign mul_lo = 32'(below_q * top_q);
  assign pos_plus4 = {1'b0, item_q.code_pos} + 12'd4;

  assign stat_o.need_mem = (item_q.mode == OP_GET);
  assign stat_o.need_div = (item_q.mode == OP_DIV) || (item_q.mode == OP_MOD);
  assign stat_o.div_done = div_done;

  always_comb begin
    st   = ST_OK;
    nxt  = item_q.code_pos;
    res  = '0;
    push = 1'b0;
    out_d = '0;
    if (DEPTH_W'(npop) > depth_q) begin
      st = ST_UNDER;
    end else begin
      unique case (item_q.mode) inside
        OP_PUSH: begin
          if (pos_plus4 > 12'(CODE_SIZE)) st = ST_CODE;
          else if (depth_q >= DEPTH_W'(STACK_DEPTH)) st = ST_OVER;
          else begin
            res  = item_q.immediate;
            push = 1'b1;
            nxt  = pos_plus4[10:0];
          end
        end
        OP_BXOR: begin res = below_q ^ top_q; push = 1'b1; end
        OP_ADD:  begin res = below_q + top_q; push = 1'b1; end
        OP_SUB:  begin res = below_q - top_q; push = 1'b1; end
        OP_MUL:  begin res = mul_lo; push = 1'b1; end
        OP_DIV, OP_MOD: begin
          if (top_q == '0) st = ST_DIVZ;
          else begin
            res  = (item_q.mode == OP_DIV) ? quo : rem;
            push = 1'b1;
          end
        end
        OP_NOT:  begin res = 32'(top_q == '0); push = 1'b1; end
        OP_AND:  begin res = 32'((below_q != '0) && (top_q != '0)); push = 1'b1; end
        OP_OR:   begin res = 32'((below_q != '0) || (top_q != '0)); push = 1'b1; end
        OP_BNOT: begin res = ~top_q; push = 1'b1; end
        OP_BAND: begin res = below_q & top_q; push = 1'b1; end
        OP_BOR:  begin res = below_q | top_q; push = 1'b1; end
        OP_GPIN: begin
          if (top_q >= 32'(GPIO_PINS)) st = ST_PIN;
          else begin
            res  = 32'(item_q.gpio_levels[top_q[4:0]]);
            push = 1'b1;
          end
        end
        OP_GPOUT: begin
          if (below_q >= 32'(GPIO_PINS)) st = ST_PIN;
          else begin
            out_d.gpio_write = 1'b1;
            out_d.gpio_pin   = below_q[4:0];
            out_d.gpio_value = (top_q != '0);
          end
        end
        OP_GET: begin res = drd_valid_q ? drd_q : '0; push = 1'b1; end
        OP_JT: begin
          if (below_q != '0) begin
            if (top_q >= 32'(CODE_SIZE)) st = ST_CODE;
            else nxt = top_q[10:0];
          end
        end
        OP_EQ:  begin res = 32'(s1 == s2); push = 1'b1; end
        OP_NEQ: begin res = 32'(s1 != s2); push = 1'b1; end
        OP_GEQ: begin res = 32'(s1 >= s2); push = 1'b1; end
        OP_LEQ: begin res = 32'(s1 <= s2); push = 1'b1; end
        OP_GT:  begin res = 32'(s1 > s2);  push = 1'b1; end
        OP_LT:  begin res = 32'(s1 < s2);  push = 1'b1; end
        default: ;
      endcase
    end
    ok    = (st == ST_OK);
    d_new = push ? d_pop + DEPTH_W'(1) : d_pop;
    if (item_q.mode == OP_STOP) begin
      d_new = '0;
      nxt   = '0;
    end
    out_d.status        = st;
    out_d.next_code_pos = ok ? nxt : item_q.code_pos;
    out_d.pushed_value  = (ok && push) ? res : '0;
    if (!ok) begin
      out_d.gpio_write = 1'b0;
      out_d.gpio_pin   = '0;
      out_d.gpio_value = 1'b0;
    end
    out_d.max_time = ((item_q.mode == OP_STOP) && (item_q.observed_time > max_q)) ?
                     item_q.observed_time : max_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      max_q    <= '0;
      dvalid_q <= '0;
    end else if (cmd_i.commit && ok) begin
      depth_q <= d_new;
      max_q   <= out_d.max_time;
      if (item_q.mode == OP_PUT) dvalid_q[daddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q  <= in_item_i;
      top_q   <= stack_mem[d_m1[SP_W-1:0]];
      below_q <= stack_mem[d_m2[SP_W-1:0]];
    end
    if (cmd_i.commit && ok && push) stack_mem[d_pop[SP_W-1:0]] <= res;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      drd_q       <= dmem[daddr];
      drd_valid_q <= dvalid_q[daddr];
    end
    if (cmd_i.commit && ok && (item_q.mode == OP_PUT)) dmem[daddr] <= below_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= out_d;
  end

  assign out_item_o = out_q;
endmodule

### rtl/core/stack_vm_execute_unit.sv
// Top level of the stack-machine execution unit: controller plus datapath.
// The unit executes one decoded stack-machine instruction per input item and
// returns exactly one result item for it, in order. Most instructions are
// accepted in the idle state, which reads the top two stack words from the
// stack memory's registered read port, and execute and write back in the
// read state. A get passes through the execute state as well, because the
// data memory read follows the stack read. Division and modulo wait in the
// divide state for the bit-serial divider, which produces one quotient bit
// per cycle. The 256-word data memory reads as zero after reset through one
// valid bit per word, so no clearing pass is needed. A finished result sits
// in an output register, and the next item is accepted while it waits; the
// unit stalls before writing a new result until the old one has been taken.
module stack_vm_execute_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  svx_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output svx_pkg::out_item_t  out_item_o
);
  import svx_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  svx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  svx_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

  // Only one item is in flight, so the unit is busy right after an accept.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while another is executing");

  // A failing instruction must not drive a pin.
  a_gpio_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.gpio_write) |-> (out_item_o.status == ST_OK))
    else $error("gpio write reported with error status");

  // A failing instruction pushes nothing.
  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ST_OK)) |-> (out_item_o.pushed_value == '0))
    else $error("pushed value reported with error status");
endmodule
